[rtl/core/artifact_color_pixel_expander_top_assert.svh]
// Assertion macros for the artifact color pixel expander.
// Used by the top level; expects clk and rst_n in scope.
`ifndef ARTIFACT_COLOR_PIXEL_EXPANDER_TOP_ASSERT_SVH
`define ARTIFACT_COLOR_PIXEL_EXPANDER_TOP_ASSERT_SVH

// checked only out of reset
`define ACPE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define ACPE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/acpe_pkg.sv]
// Types and constants shared by the artifact color pixel expander.
// No dependencies.
`default_nettype none

package acpe_pkg;

    localparam int unsigned COLOR_W = 24;
    localparam int unsigned LANES   = 5;
    localparam int unsigned CNT_W   = 3;

    typedef logic [1:0]         code_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    localparam code_t CODE_BLACK  = 2'b00;
    localparam code_t CODE_FIRST  = 2'b01;
    localparam code_t CODE_SECOND = 2'b10;
    localparam code_t CODE_WHITE  = 2'b11;

    localparam color_t COLOR_BLACK  = 24'h000000;
    localparam color_t COLOR_BLUE   = 24'h0000FF;
    localparam color_t COLOR_ORANGE = 24'hFFA500;
    localparam color_t COLOR_WHITE  = 24'hFFFFFF;

    // one pair position: its code and its two neighbors in the row
    typedef struct packed {
        code_t code;
        logic  prev_valid;
        code_t prev_code;
        logic  next_valid;
        code_t next_code;
    } lane_ctx_t;

    typedef struct packed {
        color_t left;
        color_t right;
    } pair_t;

    // load request from the front end into the output buffer
    typedef struct packed {
        logic load;
        logic first_valid;
        logic row_end;
    } load_req_t;

endpackage

`default_nettype wire

[rtl/core/acpe_if.sv]
// Channel interfaces for the artifact color pixel expander.
// Depends on acpe_pkg.
`default_nettype none

interface acpe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       row_end;

    modport source (output valid, output source_byte, output row_end, input ready);
    modport sink (input valid, input source_byte, input row_end, output ready);
endinterface

interface acpe_out_if;
    logic                 valid;
    logic                 ready;
    acpe_pkg::color_t     left_color;
    acpe_pkg::color_t     right_color;
    logic                 row_last;

    modport source (output valid, output left_color, output right_color,
                    output row_last, input ready);
    modport sink (input valid, input left_color, input right_color,
                  input row_last, output ready);
endinterface

`default_nettype wire

[rtl/core/acpe_lane.sv]
// One pixel pair lane: code to left/right RGB with the edge rules.
// Depends on acpe_pkg.
`default_nettype none

module acpe_lane (
    input  wire                 palette_swap,
    input  acpe_pkg::lane_ctx_t ctx,
    output acpe_pkg::pair_t     pair
);
    import acpe_pkg::*;

    color_t base;

    always_comb
    begin
        unique case (ctx.code)
            CODE_FIRST:  base = palette_swap ? COLOR_ORANGE : COLOR_BLUE;
            CODE_SECOND: base = palette_swap ? COLOR_BLUE : COLOR_ORANGE;
            CODE_WHITE:  base = COLOR_WHITE;
            default:     base = COLOR_BLACK;
        endcase
    end

    // right neighbor 10/11 has bit 1 set; left neighbor 01/11 has bit 0 set
    always_comb
    begin
        priority if (ctx.code == CODE_FIRST && ctx.next_valid && ctx.next_code[1])
        begin
            pair.left  = COLOR_BLACK;
            pair.right = COLOR_WHITE;
        end
        else if (ctx.code == CODE_SECOND && ctx.prev_valid && ctx.prev_code[0])
        begin
            pair.left  = COLOR_WHITE;
            pair.right = COLOR_BLACK;
        end
        else
        begin
            pair.left  = base;
            pair.right = base;
        end
    end

endmodule

`default_nettype wire

[rtl/core/acpe_merge.sv]
// Output buffer: collects the lane results of one byte and sends them in order.
// Depends on acpe_pkg and acpe_out_if.
`default_nettype none

module acpe_merge (
    input  wire                 clk,
    input  wire                 rst_n,
    input  acpe_pkg::load_req_t req,
    input  acpe_pkg::pair_t     pairs [acpe_pkg::LANES],
    output logic                can_load,
    acpe_out_if.source          pixel_out
);
    import acpe_pkg::*;

    pair_t slots_reg  [LANES];
    pair_t slots_next [LANES];
    cnt_t  count_reg, count_next;
    logic  row_end_reg, row_end_next;
    logic  pop;

    assign pop      = pixel_out.valid && pixel_out.ready;
    assign can_load = (count_reg == '0) || (count_reg == cnt_t'(1) && pixel_out.ready);

    always_comb
    begin
        slots_next   = slots_reg;
        count_next   = count_reg;
        row_end_next = row_end_reg;
        if (req.load)
        begin
            // drop the first lane when no pair was held from the previous byte
            for (int i = 0; i < LANES - 1; i++)
            begin
                if (req.first_valid)
                    slots_next[i] = pairs[i];
                else
                    slots_next[i] = pairs[i+1];
            end
            slots_next[LANES-1] = pairs[LANES-1];
            count_next   = cnt_t'(LANES - 2) + cnt_t'(req.first_valid) + cnt_t'(req.row_end);
            row_end_next = req.row_end;
        end
        else if (pop)
        begin
            for (int i = 0; i < LANES - 1; i++)
                slots_next[i] = slots_reg[i+1];
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            row_end_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            row_end_reg <= row_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

    assign pixel_out.valid       = (count_reg != '0);
    assign pixel_out.left_color  = slots_reg[0].left;
    assign pixel_out.right_color = slots_reg[0].right;
    assign pixel_out.row_last    = row_end_reg && (count_reg == cnt_t'(1));

endmodule

`default_nettype wire

[rtl/core/artifact_color_pixel_expander_top.sv]
// Top level of the artifact color pixel expander: row state, five lanes, output buffer.
// Depends on acpe_pkg, acpe_if, acpe_lane, acpe_merge and the assertion header.
//
//  channel     | dir | payload                                | handshake
//  pixel_in    | in  | source_byte[7:0], row_end              | valid/ready
//  pixel_out   | out | left_color[23:0], right_color[23:0],   | valid/ready
//              |     | row_last                               |
//  cfg         | in  | cfg_wdata (palette_swap)               | cfg_we
//
// All five lanes evaluate a taken byte at once; the results go to the output buffer,
// which sends one pair per cycle while pixel_out is ready: 3 to 5 pairs per byte.
// The next byte is taken in the cycle the last buffered pair leaves, so a stream runs
// without gaps. Reset clears the held pair, the row state, the palette and the buffer.
// A stall on pixel_out holds the buffer and holds off pixel_in.
`default_nettype none

module artifact_color_pixel_expander_top (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire        cfg_wdata,
    acpe_in_if.sink    pixel_in,
    acpe_out_if.source pixel_out
);
    import acpe_pkg::*;

    logic      palette_swap_reg;
    code_t     pend_code_reg, pend_code_next;
    logic      pend_valid_reg, pend_valid_next;
    code_t     prev_code_reg, prev_code_next;
    logic      prev_valid_reg, prev_valid_next;
    code_t     codes [4];
    lane_ctx_t ctx [LANES];
    pair_t     pairs [LANES];
    load_req_t req;
    logic      can_load;
    logic      accept;

    assign pixel_in.ready = can_load;
    assign accept         = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            codes[i] = code_t'(pixel_in.source_byte >> (6 - 2 * i));
    end

    // lane 0 is the pair held from the previous byte, lanes 1..4 are this byte
    always_comb
    begin
        ctx[0] = '{code: pend_code_reg, prev_valid: prev_valid_reg,
                   prev_code: prev_code_reg, next_valid: 1'b1, next_code: codes[0]};
        ctx[1] = '{code: codes[0], prev_valid: pend_valid_reg,
                   prev_code: pend_code_reg, next_valid: 1'b1, next_code: codes[1]};
        ctx[2] = '{code: codes[1], prev_valid: 1'b1, prev_code: codes[0],
                   next_valid: 1'b1, next_code: codes[2]};
        ctx[3] = '{code: codes[2], prev_valid: 1'b1, prev_code: codes[1],
                   next_valid: 1'b1, next_code: codes[3]};
        ctx[4] = '{code: codes[3], prev_valid: 1'b1, prev_code: codes[2],
                   next_valid: 1'b0, next_code: CODE_BLACK};
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        acpe_lane u_lane (
            .palette_swap (palette_swap_reg),
            .ctx          (ctx[g]),
            .pair         (pairs[g])
        );
    end

    assign req = '{load: accept, first_valid: pend_valid_reg, row_end: pixel_in.row_end};

    acpe_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .pairs     (pairs),
        .can_load  (can_load),
        .pixel_out (pixel_out)
    );

    always_comb
    begin
        pend_code_next  = pend_code_reg;
        pend_valid_next = pend_valid_reg;
        prev_code_next  = prev_code_reg;
        prev_valid_next = prev_valid_reg;
        if (accept)
        begin
            if (pixel_in.row_end)
            begin
                pend_code_next  = CODE_BLACK;
                pend_valid_next = 1'b0;
                prev_code_next  = CODE_BLACK;
                prev_valid_next = 1'b0;
            end
            else
            begin
                pend_code_next  = codes[3];
                pend_valid_next = 1'b1;
                prev_code_next  = codes[2];
                prev_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_swap_reg <= 1'b0;
            pend_code_reg    <= CODE_BLACK;
            pend_valid_reg   <= 1'b0;
            prev_code_reg    <= CODE_BLACK;
            prev_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                palette_swap_reg <= cfg_wdata;
            pend_code_reg  <= pend_code_next;
            pend_valid_reg <= pend_valid_next;
            prev_code_reg  <= prev_code_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

`include "artifact_color_pixel_expander_top_assert.svh"

    `ACPE_ASSERT(a_accept_fills_out, accept |=> pixel_out.valid, "no result after accepted request")
    `ACPE_ASSERT(a_row_end_clears, accept && pixel_in.row_end |=> !pend_valid_reg && !prev_valid_reg, "row state kept past row end")
    `ACPE_ASSERT(a_prev_needs_pend, prev_valid_reg |-> pend_valid_reg, "left neighbor without held pair")
    `ACPE_ASSERT_ALWAYS(a_last_needs_valid, pixel_out.row_last |-> pixel_out.valid, "row_last without valid")

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
// Testbench for artifact_color_pixel_expander_top: random and directed source bytes,
// scoreboard with its own pixel-pair predictor. Depends on acpe_pkg and acpe_if.

class pixel_pair_scoreboard;

    typedef struct {
        acpe_pkg::color_t left;
        acpe_pkg::color_t right;
        bit               last;
    } pixel_pair_t;

    pixel_pair_t    pairs_due[$];
    bit             palette_swap;
    acpe_pkg::code_t held_code;
    bit             held_valid;
    acpe_pkg::code_t left_code;
    bit             left_valid;
    int             mismatches;
    int             pairs_seen;
    int             bytes_seen;
    int             rows_seen;

    function new();
        palette_swap = 1'b0;
        held_code    = acpe_pkg::CODE_BLACK;
        held_valid   = 1'b0;
        left_code    = acpe_pkg::CODE_BLACK;
        left_valid   = 1'b0;
        mismatches   = 0;
        pairs_seen   = 0;
        bytes_seen   = 0;
        rows_seen    = 0;
    endfunction

    function void set_palette(bit swap);
        palette_swap = swap;
    endfunction

    function acpe_pkg::color_t tint(acpe_pkg::code_t c);
        case (c)
            acpe_pkg::CODE_FIRST:  return palette_swap ? acpe_pkg::COLOR_ORANGE
                                                       : acpe_pkg::COLOR_BLUE;
            acpe_pkg::CODE_SECOND: return palette_swap ? acpe_pkg::COLOR_BLUE
                                                       : acpe_pkg::COLOR_ORANGE;
            acpe_pkg::CODE_WHITE:  return acpe_pkg::COLOR_WHITE;
            default:               return acpe_pkg::COLOR_BLACK;
        endcase
    endfunction

    // held pair leaves, now that its right-hand neighbor (if any) is known
    function void push_held_pair(bit next_valid, acpe_pkg::code_t next_code, bit last);
        pixel_pair_t p;
        p.left  = tint(held_code);
        p.right = p.left;
        p.last  = last;
        if (held_code == acpe_pkg::CODE_FIRST && next_valid &&
            (next_code == acpe_pkg::CODE_SECOND || next_code == acpe_pkg::CODE_WHITE))
        begin
            p.left  = acpe_pkg::COLOR_BLACK;
            p.right = acpe_pkg::COLOR_WHITE;
        end
        else if (held_code == acpe_pkg::CODE_SECOND && left_valid &&
                 (left_code == acpe_pkg::CODE_FIRST || left_code == acpe_pkg::CODE_WHITE))
        begin
            p.left  = acpe_pkg::COLOR_WHITE;
            p.right = acpe_pkg::COLOR_BLACK;
        end
        pairs_due.push_back(p);
    endfunction

    function void note_byte(logic [7:0] src, logic row_end);
        acpe_pkg::code_t c;
        bytes_seen++;
        for (int i = 0; i < 4; i++) begin
            c = src[7 - 2*i -: 2];
            if (held_valid) begin
                push_held_pair(1'b1, c, 1'b0);
                left_code  = held_code;
                left_valid = 1'b1;
            end
            held_code  = c;
            held_valid = 1'b1;
        end
        if (row_end) begin
            push_held_pair(1'b0, acpe_pkg::CODE_BLACK, 1'b1);
            held_code  = acpe_pkg::CODE_BLACK;
            held_valid = 1'b0;
            left_code  = acpe_pkg::CODE_BLACK;
            left_valid = 1'b0;
            rows_seen++;
        end
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task check_pair(acpe_pkg::color_t left, acpe_pkg::color_t right, logic last);
        pixel_pair_t p;
        pairs_seen++;
        if (pairs_due.size() == 0) begin
            report_mismatch($sformatf("unexpected pair %06h/%06h last=%0b",
                                      left, right, last));
            return;
        end
        p = pairs_due.pop_front();
        if (left !== p.left)
            report_mismatch($sformatf("pair %0d left_color %06h, want %06h",
                                      pairs_seen, left, p.left));
        if (right !== p.right)
            report_mismatch($sformatf("pair %0d right_color %06h, want %06h",
                                      pairs_seen, right, p.right));
        if (last !== p.last)
            report_mismatch($sformatf("pair %0d row_last %0b, want %0b",
                                      pairs_seen, last, p.last));
    endtask

    function int outstanding();
        return pairs_due.size();
    endfunction

endclass

module tb;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    bit   no_idle;

    acpe_in_if  in_if();
    acpe_out_if out_if();

    pixel_pair_scoreboard board = new();

    artifact_color_pixel_expander_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixel_in  (in_if),
        .pixel_out (out_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // accepted requests on both sides, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
            board.note_byte(in_if.source_byte, in_if.row_end);
        if (rst_n && out_if.valid && out_if.ready)
            board.check_pair(out_if.left_color, out_if.right_color, out_if.row_last);
    end

    // output side back-pressure
    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_if.ready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task send_byte(logic [7:0] src, logic row_end);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 30)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.source_byte <= src;
        in_if.row_end     <= row_end;
        do @(posedge clk); while (!in_if.ready);
    endtask

    // drops valid, waits for every expected pair, then lets the pipe settle
    task drain();
        @(negedge clk);
        in_if.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_palette(bit swap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= swap;
        @(posedge clk);
        board.set_palette(swap);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function logic [7:0] pick_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        // bias toward the artifact codes so the edge rules fire often
        if ($urandom_range(99) < 45)
            for (int i = 0; i < 4; i++)
                b[2*i +: 2] = ($urandom_range(9) == 0) ? acpe_pkg::CODE_BLACK
                                                       : 2'($urandom_range(1, 3));
        return b;
    endfunction

    task send_rows(int n_bytes);
        int left_in_row;
        left_in_row = 0;
        for (int i = 0; i < n_bytes; i++)
        begin
            if (left_in_row == 0)
                left_in_row = ($urandom_range(99) < 10) ? $urandom_range(8, 20)
                                                        : $urandom_range(1, 6);
            left_in_row--;
            send_byte(pick_byte(), (left_in_row == 0) || (i == n_bytes - 1));
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        no_idle           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.source_byte = 8'h00;
        in_if.row_end     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_palette(1'b0);

        // plain codes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b1);
        // one-byte rows with both edge rules inside
        send_byte(8'h66, 1'b1);
        send_byte(8'h79, 1'b1);
        send_byte(8'h5A, 1'b1);
        // rules across a byte boundary inside a row
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h80, 1'b1);
        // no rule across a row boundary
        send_byte(8'h01, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'h03, 1'b1);
        send_byte(8'hBF, 1'b1);
        send_byte(8'hE4, 1'b1);
        send_byte(8'h1B, 1'b1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        drain();

        write_palette(1'b1);
        no_idle = 1'b1;
        send_rows(60);
        no_idle = 1'b0;
        send_rows(80);
        drain();

        write_palette(1'b0);
        send_rows(140);
        drain();

        write_palette(1'b1);
        send_rows(130);
        drain();

        if (board.outstanding() != 0)
            board.report_mismatch($sformatf("%0d expected pairs never arrived",
                                            board.outstanding()));
        $display("Covered %0d source bytes in %0d rows, %0d pixel pairs checked,",
                 board.bytes_seen, board.rows_seen, board.pairs_seen);
        $display("both palette settings, random stalls on both channels; %0d mismatches",
                 board.mismatches);
        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/acpe_pkg.sv
rtl/core/acpe_if.sv
rtl/core/acpe_lane.sv
rtl/core/acpe_merge.sv
rtl/core/artifact_color_pixel_expander_top.sv
verif/tb.sv
